FILE: hw/rtl/sqlf_pkg.sv
// Shared types and constants for the store queue with load forwarding.
// Holds command and status codes, sequencer states and the queue entry layout.
// No dependencies.
package sqlf_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned TAG_W  = 32;
  localparam int unsigned ADDR_W = 64;
  localparam int unsigned SIZE_W = 4;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned BYTES  = DATA_W / 8;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned STAT_W = 2;

  localparam logic [SIZE_W-1:0] MAX_SIZE  = SIZE_W'(BYTES);
  localparam logic [7:0]        BYTE_MASK = 8'hff;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DRAIN  = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NONE   = 2'd3
  } sqlf_cmd_t;

  localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_MISSING = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } sqlf_state_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] size;
    logic [DATA_W-1:0] data;
  } sqlf_entry_t;

  localparam int unsigned ENTRY_W = $bits(sqlf_entry_t);

endpackage

FILE: hw/rtl/store_queue_load_forwarding.sv
// Store queue with store-to-load forwarding for one hart: top level.
// Depends on sqlf_pkg and the entry memory sqlf_ram.
//
// Usage:
//   A word is taken at a rising edge with start high and busy low. in_command
//   selects insert (record a store, replacing one with the same tag), drain
//   (remove a store by tag, return address, size and data) or load lookup
//   (merge queued store bytes over the supplied memory bytes).
//   Each word gives exactly one result, shown on the out_ ports for one cycle
//   with out_strobe high; the receiver takes it in that cycle and cannot stall.
//   Timing: every command sweeps the entry memory once, one entry per cycle
//   through its single registered read port, then performs the
//   write-back. busy stays high over the sweep and write-back from the accepting
//   edge; out_strobe is high in the cycle after busy falls, and a new word may
//   be taken at the edge that ends that cycle. A new word is not taken while busy
//   is high, so each word completes before the next is accepted.
//   Reset: synchronous, active low; clears all entry valid bits and the
//   sequencer. Entry contents are not cleared; an entry's contents are only used
//   while its valid bit is set.
module store_queue_load_forwarding #(
  parameter int unsigned QUEUE_DEPTH = sqlf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [sqlf_pkg::CMD_W-1:0]  in_command,
  input  logic [sqlf_pkg::TAG_W-1:0]  in_tag,
  input  logic [sqlf_pkg::ADDR_W-1:0] in_address,
  input  logic [sqlf_pkg::SIZE_W-1:0] in_size,
  input  logic [sqlf_pkg::DATA_W-1:0] in_data,
  output logic                        out_strobe,
  output logic [sqlf_pkg::STAT_W-1:0] out_status,
  output logic [sqlf_pkg::DATA_W-1:0] out_result_data,
  output logic [sqlf_pkg::BYTES-1:0]  out_forwarded_mask,
  output logic [sqlf_pkg::ADDR_W-1:0] out_result_address,
  output logic [sqlf_pkg::SIZE_W-1:0] out_result_size
);

  import sqlf_pkg::*;

  localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(QUEUE_DEPTH);

  sqlf_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_m1;
  logic [IW-1:0] proc_idx;
  logic [QUEUE_DEPTH-1:0] valid_r;

  sqlf_cmd_t         cmd_r;
  logic [TAG_W-1:0]  tag_r;
  logic [ADDR_W-1:0] addr_r;
  logic [SIZE_W-1:0] size_r;
  logic [DATA_W-1:0] data_r;
  logic [SIZE_W-1:0] size_clamp;

  logic              found_r, free_found_r;
  logic [IW-1:0]     hit_idx_r, free_idx_r;
  logic [ADDR_W-1:0] drn_addr_r;
  logic [SIZE_W-1:0] drn_size_r;
  logic [DATA_W-1:0] drn_data_r;

  logic [BYTES-1:0]  lane_hit_r, lane_take;
  logic [TAG_W-1:0]  lane_tag_r  [BYTES];
  logic [7:0]        lane_byte_r [BYTES];
  logic [7:0]        lane_pick   [BYTES];

  logic              accept, rd_en, proc_en, finish;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  sqlf_entry_t       wr_entry, rd_entry;
  logic [ENTRY_W-1:0] rd_word;

  logic              ent_valid, ent_match, tag_ok, near;
  logic [ADDR_W-1:0] off0;
  logic [5:0]        lane_off;

  logic              out_strobe_r;
  logic [STAT_W-1:0] out_status_r, status_fin;
  logic [DATA_W-1:0] out_data_r, data_fin;
  logic [BYTES-1:0]  out_mask_r, mask_fin;
  logic [ADDR_W-1:0] out_addr_r, addr_fin;
  logic [SIZE_W-1:0] out_size_r, size_fin;

  assign size_clamp = (in_size > MAX_SIZE) ? MAX_SIZE : in_size;
  assign cnt_m1     = cnt_r - CW'(1);
  assign proc_idx   = cnt_m1[IW-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (cnt_r == LAST_CNT) state_nxt = S_FINISH;
      end
      S_FINISH: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy    = 1'b1;
    rd_en   = 1'b0;
    proc_en = 1'b0;
    finish  = 1'b0;
    unique case (state_r)
      S_IDLE:   busy = 1'b0;
      S_SCAN: begin
        rd_en   = (cnt_r != LAST_CNT);
        proc_en = (cnt_r != '0);
      end
      S_FINISH: finish = 1'b1;
      default:  busy = 1'b0;
    endcase
  end

  assign accept = start && !busy;

  assign wr_entry = '{tag: tag_r, address: addr_r, size: size_r, data: data_r};
  assign wr_en    = finish && (cmd_r == CMD_INSERT) && (found_r || free_found_r);
  assign wr_addr  = found_r ? hit_idx_r : free_idx_r;

  sqlf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH),
    .AW    (IW)
  ) u_entries (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (cnt_r[IW-1:0]),
    .rd_data (rd_word)
  );

  assign rd_entry = sqlf_entry_t'(rd_word);

  // entry compare and per-lane forwarding check
  always_comb begin
    ent_valid = valid_r[proc_idx];
    ent_match = ent_valid && (rd_entry.tag == tag_r);
    tag_ok    = ent_valid && (rd_entry.tag <= tag_r);
    off0      = addr_r - rd_entry.address;
    near      = (off0[ADDR_W-1:3] == '0) || (off0[ADDR_W-1:3] == '1);
    lane_off  = '0;
    for (int i = 0; i < BYTES; i++) begin
      lane_off     = {off0[4], off0[4:0]} + 6'(i);
      lane_take[i] = tag_ok && near && !lane_off[5]
                     && (lane_off < {2'b00, rd_entry.size})
                     && (SIZE_W'(i) < size_r)
                     && (!lane_hit_r[i] || (rd_entry.tag > lane_tag_r[i]));
      lane_pick[i] = rd_entry.data[8*lane_off[2:0] +: 8];
    end
  end

  // result assembly at the end of the sweep
  always_comb begin
    status_fin = STATUS_OK;
    data_fin   = '0;
    mask_fin   = '0;
    addr_fin   = '0;
    size_fin   = '0;
    unique case (cmd_r)
      CMD_INSERT: begin
        if (!found_r && !free_found_r) status_fin = STATUS_FULL;
      end
      CMD_DRAIN: begin
        if (found_r) begin
          addr_fin = drn_addr_r;
          size_fin = drn_size_r;
          for (int b = 0; b < BYTES; b++) begin
            if (SIZE_W'(b) < drn_size_r) data_fin[8*b +: 8] = drn_data_r[8*b +: 8];
          end
        end else begin
          status_fin = STATUS_MISSING;
        end
      end
      CMD_LOOKUP: begin
        mask_fin = lane_hit_r;
        for (int b = 0; b < BYTES; b++) begin
          if (lane_hit_r[b]) begin
            data_fin[8*b +: 8] = lane_byte_r[b];
          end else if (SIZE_W'(b) < size_r) begin
            data_fin[8*b +: 8] = data_r[8*b +: 8] & BYTE_MASK;
          end
        end
      end
      default: status_fin = STATUS_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      valid_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= finish;
      if (accept) begin
        cnt_r <= '0;
      end else if (state_r == S_SCAN && cnt_r != LAST_CNT) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (finish && cmd_r == CMD_DRAIN && found_r) begin
        valid_r[hit_idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r        <= sqlf_cmd_t'(in_command);
      tag_r        <= in_tag;
      addr_r       <= in_address;
      size_r       <= size_clamp;
      data_r       <= in_data;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      lane_hit_r   <= '0;
    end else if (proc_en) begin
      if (ent_match && !found_r) begin
        found_r    <= 1'b1;
        hit_idx_r  <= proc_idx;
        drn_addr_r <= rd_entry.address;
        drn_size_r <= rd_entry.size;
        drn_data_r <= rd_entry.data;
      end
      if (!ent_valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= proc_idx;
      end
      for (int i = 0; i < BYTES; i++) begin
        if (lane_take[i]) begin
          lane_hit_r[i]  <= 1'b1;
          lane_tag_r[i]  <= rd_entry.tag;
          lane_byte_r[i] <= lane_pick[i];
        end
      end
    end
    if (finish) begin
      out_status_r <= status_fin;
      out_data_r   <= data_fin;
      out_mask_r   <= mask_fin;
      out_addr_r   <= addr_fin;
      out_size_r   <= size_fin;
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_status         = out_status_r;
  assign out_result_data    = out_data_r;
  assign out_forwarded_mask = out_mask_r;
  assign out_result_address = out_addr_r;
  assign out_result_size    = out_size_r;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepting a word");

  a_strobe_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH) |=> out_strobe)
    else $error("no result after the write-back cycle");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held longer than one cycle");

  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == STATUS_FULL) |-> (&valid_r))
    else $error("queue full reported with a free entry");
`endif

endmodule

FILE: hw/rtl/sqlf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Parameters set word width and depth. No dependencies.
module sqlf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: bench/tb.sv
// Self-checking bench for store_queue_load_forwarding: directed and random store, drain and
// load words with an in-bench prediction of queue contents and forwarded load bytes.
// Depends on sqlf_pkg and the store_queue_load_forwarding RTL.
`timescale 1ns / 1ps

module tb;
  import sqlf_pkg::*;

  localparam int unsigned QD = QUEUE_DEPTH_DEF;

  typedef struct packed {
    bit                barrier;
    int unsigned       idle_pct;
    sqlf_cmd_t         cmd;
    logic [TAG_W-1:0]  tag;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    logic [DATA_W-1:0] data;
  } sq_word_t;

  typedef struct packed {
    sqlf_cmd_t         cmd;
    logic [TAG_W-1:0]  tag;
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] data;
    logic [BYTES-1:0]  mask;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } sq_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [CMD_W-1:0] in_command;
  logic [TAG_W-1:0] in_tag;
  logic [ADDR_W-1:0] in_address;
  logic [SIZE_W-1:0] in_size;
  logic [DATA_W-1:0] in_data;
  logic out_strobe;
  logic [STAT_W-1:0] out_status;
  logic [DATA_W-1:0] out_result_data;
  logic [BYTES-1:0] out_forwarded_mask;
  logic [ADDR_W-1:0] out_result_address;
  logic [SIZE_W-1:0] out_result_size;

  sq_word_t word_q[$];
  sq_result_t responses_due[$];
  logic [TAG_W-1:0] live_tags[$];
  logic [TAG_W-1:0] next_tag;
  logic [ADDR_W-1:0] win_base;
  int unsigned gen_idle;
  bit took_word;

  bit sq_valid[QD];
  logic [TAG_W-1:0] sq_tag[QD];
  logic [ADDR_W-1:0] sq_addr[QD];
  logic [SIZE_W-1:0] sq_size[QD];
  logic [DATA_W-1:0] sq_data[QD];

  int unsigned errors, n_words, n_insert, n_full, n_drain, n_missing;
  int unsigned n_lookup, n_fwd_bytes, n_unused, n_pauses;

  store_queue_load_forwarding #(.QUEUE_DEPTH(QD)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_tag(in_tag), .in_address(in_address),
    .in_size(in_size), .in_data(in_data),
    .out_strobe(out_strobe), .out_status(out_status), .out_result_data(out_result_data),
    .out_forwarded_mask(out_forwarded_mask), .out_result_address(out_result_address),
    .out_result_size(out_result_size)
  );

  always #6 clk = ~clk;

  task automatic resolve_command(input sqlf_cmd_t cmd, input logic [TAG_W-1:0] tag,
                                 input logic [ADDR_W-1:0] addr, input logic [SIZE_W-1:0] size_in,
                                 input logic [DATA_W-1:0] data, output sq_result_t r);
    int slot;
    int unsigned sz, i, j;
    logic [ADDR_W-1:0] ba, off;
    logic [7:0] b;
    bit hit;
    logic [TAG_W-1:0] best;
    r = '0;
    r.cmd = cmd;
    r.tag = tag;
    sz = (size_in > MAX_SIZE) ? MAX_SIZE : size_in;
    slot = -1;
    for (j = 0; j < QD; j++)
      if (slot < 0 && sq_valid[j] && sq_tag[j] == tag) slot = j;
    case (cmd)
      CMD_INSERT: begin
        for (j = 0; j < QD; j++)
          if (slot < 0 && !sq_valid[j]) slot = j;
        if (slot < 0) begin
          r.status = STATUS_FULL;
        end else begin
          sq_valid[slot] = 1'b1;
          sq_tag[slot] = tag;
          sq_addr[slot] = addr;
          sq_size[slot] = SIZE_W'(sz);
          sq_data[slot] = data;
        end
      end
      CMD_DRAIN: begin
        if (slot < 0) begin
          r.status = STATUS_MISSING;
        end else begin
          r.addr = sq_addr[slot];
          r.size = sq_size[slot];
          for (i = 0; i < sq_size[slot]; i++) r.data[i*8 +: 8] = sq_data[slot][i*8 +: 8];
          sq_valid[slot] = 1'b0;
        end
      end
      CMD_LOOKUP: begin
        for (i = 0; i < sz; i++) begin
          ba = addr + ADDR_W'(i);
          b = data[i*8 +: 8];
          hit = 1'b0;
          best = '0;
          for (j = 0; j < QD; j++) begin
            off = ba - sq_addr[j];
            if (sq_valid[j] && sq_tag[j] <= tag && off < ADDR_W'(sq_size[j]) &&
                (!hit || sq_tag[j] > best)) begin
              hit = 1'b1;
              best = sq_tag[j];
              b = sq_data[j][off[2:0]*8 +: 8];
            end
          end
          r.mask[i] = hit;
          r.data[i*8 +: 8] = b;
        end
      end
      default: ;
    endcase
  endtask

  task automatic queue_word(input sqlf_cmd_t cmd, input logic [TAG_W-1:0] tag,
                            input logic [ADDR_W-1:0] addr, input logic [SIZE_W-1:0] size,
                            input logic [DATA_W-1:0] data);
    sq_word_t w;
    w.barrier = 1'b0;
    w.idle_pct = gen_idle;
    w.cmd = cmd;
    w.tag = tag;
    w.addr = addr;
    w.size = size;
    w.data = data;
    word_q.push_back(w);
  endtask

  task automatic queue_barrier();
    sq_word_t w;
    w = '0;
    w.barrier = 1'b1;
    word_q.push_back(w);
  endtask

  task automatic queue_random_traffic(input int unsigned count);
    int unsigned n, pick, k;
    logic [TAG_W-1:0] t;
    logic [ADDR_W-1:0] a;
    logic [SIZE_W-1:0] s;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      a = win_base + ADDR_W'($urandom_range(0, 31));
      s = ($urandom_range(3) == 0) ? SIZE_W'($urandom_range(0, 15))
                                   : SIZE_W'(1 << $urandom_range(0, 3));
      if (pick < 35) begin
        if (live_tags.size() > 0 && $urandom_range(9) == 0) begin
          t = live_tags[$urandom_range(live_tags.size() - 1)];
        end else begin
          next_tag = next_tag + TAG_W'($urandom_range(1, 4));
          t = next_tag;
          if (live_tags.size() < QD) live_tags.push_back(t);
        end
        queue_word(CMD_INSERT, t, a, s, {$urandom, $urandom});
      end else if (pick < 65) begin
        if (live_tags.size() == 0 || $urandom_range(9) == 0) begin
          t = $urandom;
        end else begin
          k = ($urandom_range(1) == 0) ? 0 : $urandom_range(live_tags.size() - 1);
          t = live_tags[k];
          live_tags.delete(k);
        end
        queue_word(CMD_DRAIN, t, a, s, {$urandom, $urandom});
      end else if (pick < 95) begin
        if (live_tags.size() > 0 && $urandom_range(2) == 0)
          t = live_tags[$urandom_range(live_tags.size() - 1)] - TAG_W'($urandom_range(0, 1));
        else
          t = next_tag;
        s = ($urandom_range(9) == 0) ? SIZE_W'($urandom_range(0, 15))
                                     : SIZE_W'($urandom_range(1, 8));
        queue_word(CMD_LOOKUP, t, a, s, {$urandom, $urandom});
      end else begin
        queue_word(sqlf_cmd_t'($urandom_range(1, 3)), $urandom, {$urandom, $urandom},
                   SIZE_W'($urandom), {$urandom, $urandom});
      end
    end
  endtask

  always @(negedge clk) begin
    sq_word_t w;
    bit go;
    go = 1'b0;
    w = '0;
    if (!rst_n) begin
      start <= 1'b0;
      in_command <= '0;
      in_tag <= '0;
      in_address <= '0;
      in_size <= '0;
      in_data <= '0;
    end else if (!(start && !took_word)) begin
      if (word_q.size() > 0) begin
        if (word_q[0].barrier) begin
          if (responses_due.size() == 0) begin
            void'(word_q.pop_front());
            n_pauses++;
          end
        end else if ($urandom_range(99) >= word_q[0].idle_pct) begin
          w = word_q.pop_front();
          go = 1'b1;
        end
      end
      if (go) begin
        in_command <= w.cmd;
        in_tag <= w.tag;
        in_address <= w.addr;
        in_size <= w.size;
        in_data <= w.data;
      end else begin
        in_command <= CMD_W'($urandom);
        in_tag <= $urandom;
        in_address <= {$urandom, $urandom};
        in_size <= SIZE_W'($urandom);
        in_data <= {$urandom, $urandom};
      end
      start <= go;
    end
  end

  always @(posedge clk) begin
    sq_result_t e, got;
    if (!rst_n) begin
      took_word <= 1'b0;
    end else begin
      took_word <= start && !busy;
      if (out_strobe) begin
        got = '0;
        got.status = out_status;
        got.data = out_result_data;
        got.mask = out_forwarded_mask;
        got.addr = out_result_address;
        got.size = out_result_size;
        if (responses_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: status %0d data %h mask %h addr %h size %0d",
                     got.status, got.data, got.mask, got.addr, got.size);
        end else begin
          e = responses_due.pop_front();
          if (got.status !== e.status || got.data !== e.data || got.mask !== e.mask ||
              got.addr !== e.addr || got.size !== e.size) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch on %s tag %h:", e.cmd.name(), e.tag);
              $display("  expected status %0d data %h mask %h addr %h size %0d",
                       e.status, e.data, e.mask, e.addr, e.size);
              $display("  got      status %0d data %h mask %h addr %h size %0d",
                       got.status, got.data, got.mask, got.addr, got.size);
            end
          end
        end
      end
      if (start && !busy) begin
        resolve_command(sqlf_cmd_t'(in_command), in_tag, in_address, in_size, in_data, e);
        responses_due.push_back(e);
        n_words++;
        case (e.cmd)
          CMD_INSERT: begin
            n_insert++;
            if (e.status == STATUS_FULL) n_full++;
          end
          CMD_DRAIN: begin
            n_drain++;
            if (e.status == STATUS_MISSING) n_missing++;
          end
          CMD_LOOKUP: begin
            n_lookup++;
            n_fwd_bytes += $countones(e.mask);
          end
          default: n_unused++;
        endcase
      end
    end
  end

  initial begin
    int unsigned k;
    rst_n = 1'b0;
    gen_idle = 0;

    queue_word(CMD_LOOKUP, 32'd5, 64'h1000, 4'd8, {$urandom, $urandom});
    queue_word(CMD_NONE, 32'd5, 64'h1000, 4'd8, {$urandom, $urandom});
    queue_word(CMD_DRAIN, 32'd7, 64'h0, 4'd0, 64'h0);
    queue_word(CMD_LOOKUP, 32'd9, 64'h1000, 4'd0, {$urandom, $urandom});
    queue_word(CMD_INSERT, 32'd0, 64'h0, 4'd1, '1);
    queue_word(CMD_INSERT, 32'd10, 64'hFFFF_FFFF_FFFF_FFFC, 4'd8, 64'h1122_3344_5566_7788);
    queue_word(CMD_INSERT, 32'd12, 64'hFFFF_FFFF_FFFF_FFFE, 4'd15, 64'hA5A5_5A5A_C3C3_3C3C);
    queue_word(CMD_INSERT, 32'd10, 64'hFFFF_FFFF_FFFF_FFFC, 4'd8, 64'h99AA_BBCC_DDEE_FF00);
    queue_word(CMD_LOOKUP, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF8, 4'd15, '1);
    queue_word(CMD_LOOKUP, 32'd11, 64'hFFFF_FFFF_FFFF_FFFE, 4'd8, 64'h0);
    queue_word(CMD_INSERT, 32'd20, 64'h40, 4'd0, {$urandom, $urandom});
    queue_word(CMD_INSERT, 32'd21, 64'h40, 4'd3, {$urandom, $urandom});
    queue_word(CMD_INSERT, 32'd22, 64'h42, 4'd5, {$urandom, $urandom});
    queue_word(CMD_INSERT, 32'd23, 64'h45, 4'd6, {$urandom, $urandom});
    queue_word(CMD_INSERT, 32'd24, 64'h47, 4'd7, {$urandom, $urandom});
    queue_word(CMD_LOOKUP, 32'd30, 64'h40, 4'd8, {$urandom, $urandom});
    live_tags = '{32'd0, 32'd21, 32'd22, 32'd23, 32'd24};
    for (k = 40; k < 48; k++) begin
      queue_word(CMD_INSERT, TAG_W'(k), 64'h40 + ADDR_W'($urandom_range(0, 15)),
                 SIZE_W'(1 << $urandom_range(0, 3)), {$urandom, $urandom});
      live_tags.push_back(TAG_W'(k));
    end
    queue_word(CMD_INSERT, 32'd48, 64'h50, 4'd8, {$urandom, $urandom});
    queue_word(CMD_INSERT, 32'd0, 64'h48, 4'd2, {$urandom, $urandom});
    queue_word(CMD_DRAIN, 32'd20, 64'h0, 4'd0, 64'h0);
    queue_word(CMD_DRAIN, 32'd12, 64'h0, 4'd0, 64'h0);
    queue_word(CMD_DRAIN, 32'd10, 64'h0, 4'd0, 64'h0);

    next_tag = 32'd100;
    win_base = 64'h1000;
    queue_barrier();
    queue_random_traffic(270);
    gen_idle = 67;
    next_tag = 32'h0001_0000;
    win_base = 64'hFFFF_FFFF_FFFF_FFF0;
    queue_barrier();
    queue_random_traffic(270);
    gen_idle = 31;
    next_tag = 32'h8000_0000;
    win_base = {$urandom, $urandom};
    queue_barrier();
    queue_random_traffic(270);
    gen_idle = 0;
    next_tag = 32'hFFFF_F000;
    win_base = {$urandom, $urandom};
    queue_barrier();
    queue_random_traffic(270);

    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (word_q.size() != 0 || start || responses_due.size() != 0) @(posedge clk);
    repeat (QD + 5) @(posedge clk);

    $display("covered %0d words: %0d inserts (%0d full), %0d drains (%0d missing tag),",
             n_words, n_insert, n_full, n_drain, n_missing);
    $display("%0d lookups forwarding %0d bytes, %0d unused commands, %0d drain pauses",
             n_lookup, n_fwd_bytes, n_unused, n_pauses);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
